[src/ipps_pkg.sv]
package ipps_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'

   localparam int unsigned SECT_W     = 3;
   localparam int unsigned VALUE_W    = 17;
   localparam int unsigned PROD_W     = 21;

   localparam logic [SECT_W-1:0]  LAST_OCTET   = 3'd3;
   localparam logic [SECT_W-1:0]  PORT_SECTION = 3'd4;
   localparam logic [VALUE_W-1:0] OCTET_MAX    = 17'd255;
   localparam logic [VALUE_W-1:0] PORT_MAX     = 17'd65535;
   localparam logic [VALUE_W-1:0] VALUE_SAT    = 17'd65536;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic        address_valid;
      logic [31:0] ip_address;
      logic [15:0] port_number;
   } rsp_type;

endpackage

[src/ipv4_port_string_parser.sv]
// Path: the last character is held in the input register; its result is then
//   loaded into the result register once that is free, and drives rsp_valid.
// Throughput: one character per cycle; a result waiting in the output register
//   does not block intake until the next end-of-string character reaches it.
// Reset: synchronous, active high; clears both pipeline valids and the parse
//   state (section, field value, flags, octet accumulator).
module ipv4_port_string_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ipps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipps_pkg::rsp_type rsp_data
);
   import ipps_pkg::*;

   // input register stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // parse state
   logic [SECT_W-1:0]  section_ff, section_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               has_digit_ff, has_digit_in;
   logic               lead_zero_ff, lead_zero_in;
   logic               bad_ff, bad_in;
   logic [31:0]        octets_ff, octets_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic              out_free;   // result register can take a new transfer
   logic              s1_adv;     // character in stage 1 is processed this cycle
   logic              is_digit;
   logic [PROD_W-1:0] prod;
   logic              octet_ok;
   logic              str_ok;
   logic [15:0]       port_val;   // port field as it stands after the final character

   assign out_free  = !out_valid_ff || !rsp_stall;
   // a non-final character never needs the output; a final one needs a free slot
   assign s1_adv    = s1_valid_ff && (!s1_data_ff.end_of_string || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;

   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !s1_adv);

   assign is_digit = s1_data_ff.char_code inside {[CHAR_ZERO:CHAR_NINE]};
   // value*10 + digit; ASCII digits carry the digit in the low nibble
   assign prod = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
               + {{(PROD_W-4){1'b0}}, s1_data_ff.char_code[3:0]};
   assign octet_ok = has_digit_ff && (value_ff <= OCTET_MAX);

   // next parse state
   always_comb begin
      section_in   = section_ff;
      value_in     = value_ff;
      has_digit_in = has_digit_ff;
      lead_zero_in = lead_zero_ff;
      bad_in       = bad_ff;
      octets_in    = octets_ff;
      str_ok       = 1'b0;
      port_val     = '0;

      if (!bad_ff) begin
         if (is_digit) begin
            if (lead_zero_ff) begin
               bad_in = 1'b1;
            end else begin
               if (!has_digit_ff && s1_data_ff.char_code == CHAR_ZERO) begin
                  lead_zero_in = 1'b1;
               end
               has_digit_in = 1'b1;
               // saturate so long digit runs can never wrap into range
               if (prod > {{(PROD_W-VALUE_W){1'b0}}, VALUE_SAT}) begin
                  value_in = VALUE_SAT;
               end else begin
                  value_in = prod[VALUE_W-1:0];
               end
            end
         end else if (s1_data_ff.char_code == CHAR_DOT ||
                      s1_data_ff.char_code == CHAR_COLON) begin
            // dot closes octets 0..2, colon closes only octet 3
            if (((s1_data_ff.char_code == CHAR_DOT) ? (section_ff < LAST_OCTET)
                                                    : (section_ff == LAST_OCTET))
                && octet_ok) begin
               octets_in    = {octets_ff[23:0], value_ff[7:0]};
               section_in   = section_ff + 1'b1;
               value_in     = '0;
               has_digit_in = 1'b0;
               lead_zero_in = 1'b0;
            end else begin
               bad_in = 1'b1;
            end
         end else begin
            bad_in = 1'b1;
         end
      end

      // judge the string after its final character, then start over
      if (s1_data_ff.end_of_string) begin
         str_ok = !bad_in && section_in == PORT_SECTION && has_digit_in
                  && value_in <= PORT_MAX;
         port_val     = value_in[15:0];
         section_in   = '0;
         value_in     = '0;
         has_digit_in = 1'b0;
         lead_zero_in = 1'b0;
         bad_in       = 1'b0;
         octets_in    = '0;
      end
   end

   // result register load
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (s1_adv && s1_data_ff.end_of_string) begin
         out_valid_in              = 1'b1;
         out_data_in.address_valid = str_ok;
         out_data_in.ip_address    = str_ok ? octets_ff : '0;
         out_data_in.port_number   = str_ok ? port_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         section_ff   <= '0;
         value_ff     <= '0;
         has_digit_ff <= 1'b0;
         lead_zero_ff <= 1'b0;
         bad_ff       <= 1'b0;
         octets_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            section_ff   <= section_in;
            value_ff     <= value_in;
            has_digit_ff <= has_digit_in;
            lead_zero_ff <= lead_zero_in;
            bad_ff       <= bad_in;
            octets_ff    <= octets_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
